/* design/bcr_pkg.sv */
// shared types, codes and constants for the branch/call/return resolver
`timescale 1ns / 1ps

package bcr_pkg;

  // command codes as they arrive on the input channel
  typedef enum logic [3:0] {
    CMD_DJNZ     = 4'd0,
    CMD_JR       = 4'd1,
    CMD_LJP      = 4'd2,
    CMD_CALL     = 4'd3,
    CMD_LCALL    = 4'd4,
    CMD_RST      = 4'd5,
    CMD_JR_CC    = 4'd6,
    CMD_RET_CC   = 4'd7,
    CMD_JP_CC    = 4'd8,
    CMD_LRET     = 4'd9,
    CMD_RETI     = 4'd10,
    CMD_SYSCALL  = 4'd11,
    CMD_DWJNZ    = 4'd12,
    CMD_LLJP_CX  = 4'd13,
    CMD_LLJP_CC  = 4'd14
  } cmd_t;

  // operation classes handed from front to back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DJNZ,
    OP_JUMP,
    OP_LJP,
    OP_CALL,
    OP_LCALL,
    OP_RET,
    OP_LRET,
    OP_RETI,
    OP_DWJNZ,
    OP_LLJP
  } op_t;

  // flag bit positions
  localparam int unsigned FLAG_S_BIT = 7;
  localparam int unsigned FLAG_Z_BIT = 6;
  localparam int unsigned FLAG_V_BIT = 2;
  localparam int unsigned FLAG_C_BIT = 0;

  // restart opcode that debug mode blocks
  localparam logic [7:0] OPC_RST_DEBUG = 8'hef;
  // low byte of the syscall vector
  localparam logic [7:0] SYSCALL_VEC_LO = 8'h60;

  // field widths
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 112;

  // classified item between front and back
  typedef struct packed {
    op_t         op;
    logic        exec;
    logic [15:0] target;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] cnt;
    logic [15:0] imm_hi;
    logic [23:0] pop;
    logic [7:0]  xpc;
  } item_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // one resolved result
  typedef struct packed {
    logic        taken;
    logic [23:0] push_bytes;
    logic [1:0]  push_count;
    logic        ip_write;
    logic [7:0]  ip_next;
    logic        lxpc_write;
    logic [11:0] lxpc_next;
    logic        xpc_write;
    logic [7:0]  xpc_next;
    logic [15:0] count_next;
    logic [15:0] sp_next;
    logic [15:0] pc_next;
  } res_t;

endpackage

/* design/bcr_front.sv */
// front end: takes input transfers, holds the config bit, classifies commands
`timescale 1ns / 1ps

module bcr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bcr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [bcr_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  bcr_pkg::q_status_t               q_status,
  output logic                             push,
  output bcr_pkg::item_t                   push_item
);

  logic        rst_ef_blocked_r;
  logic        rst_ef_blocked_nxt;

  logic [7:0]  opcode;
  logic [15:0] pc_now;
  logic [15:0] sp_now;
  logic [15:0] count_now;
  logic [7:0]  flag_byte;
  logic        cond_in;
  logic [31:0] imm;
  logic [23:0] pop_bytes;
  logic [7:0]  xpc_now;
  logic [7:0]  iir_now;
  logic [15:0] rel_tgt;
  logic        fs, fz, fv, fc, sxv;
  logic        cond_signed;
  logic        cond_plain;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    rst_ef_blocked_nxt = rst_ef_blocked_r;
    if (cfg_valid) begin
      rst_ef_blocked_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_ef_blocked_r <= 1'b0;
    end else begin
      rst_ef_blocked_r <= rst_ef_blocked_nxt;
    end
  end

  // unpack input fields
  assign opcode    = in_tdata[7:0];
  assign pc_now    = in_tdata[23:8];
  assign sp_now    = in_tdata[39:24];
  assign count_now = in_tdata[55:40];
  assign flag_byte = in_tdata[63:56];
  assign cond_in   = in_tdata[64];
  assign imm       = in_tdata[96:65];
  assign pop_bytes = in_tdata[120:97];
  assign xpc_now   = in_tdata[128:121];
  assign iir_now   = in_tdata[136:129];

  // handshake to the queue
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

  // relative target with sign-extended displacement
  assign rel_tgt = pc_now + {{8{imm[7]}}, imm[7:0]};

  // far jump conditions
  assign fs  = flag_byte[bcr_pkg::FLAG_S_BIT];
  assign fz  = flag_byte[bcr_pkg::FLAG_Z_BIT];
  assign fv  = flag_byte[bcr_pkg::FLAG_V_BIT];
  assign fc  = flag_byte[bcr_pkg::FLAG_C_BIT];
  assign sxv = fs ^ fv;

  always_comb begin
    case (opcode[4:3])
      2'd0:    cond_signed = !(fz || sxv);
      2'd1:    cond_signed = !fc && !fz;
      2'd2:    cond_signed = sxv;
      default: cond_signed = fv;
    endcase
    case (opcode[4:3])
      2'd0:    cond_plain = !fz;
      2'd1:    cond_plain = fz;
      2'd2:    cond_plain = !fc;
      default: cond_plain = fc;
    endcase
  end

  // classify the command
  always_comb begin
    push_item        = '0;
    push_item.op     = bcr_pkg::OP_NONE;
    push_item.exec   = 1'b1;
    push_item.target = imm[15:0];
    push_item.pc     = pc_now;
    push_item.sp     = sp_now;
    push_item.cnt    = count_now;
    push_item.imm_hi = imm[31:16];
    push_item.pop    = pop_bytes;
    push_item.xpc    = xpc_now;
    case (bcr_pkg::cmd_t'(in_tuser))
      bcr_pkg::CMD_DJNZ: begin
        push_item.op     = bcr_pkg::OP_DJNZ;
        push_item.target = rel_tgt;
      end
      bcr_pkg::CMD_JR: begin
        push_item.op     = bcr_pkg::OP_JUMP;
        push_item.target = rel_tgt;
      end
      bcr_pkg::CMD_JR_CC: begin
        push_item.op     = bcr_pkg::OP_JUMP;
        push_item.exec   = cond_in;
        push_item.target = rel_tgt;
      end
      bcr_pkg::CMD_JP_CC: begin
        push_item.op   = bcr_pkg::OP_JUMP;
        push_item.exec = cond_in;
      end
      bcr_pkg::CMD_LJP: begin
        push_item.op = bcr_pkg::OP_LJP;
      end
      bcr_pkg::CMD_CALL: begin
        push_item.op = bcr_pkg::OP_CALL;
      end
      bcr_pkg::CMD_LCALL: begin
        push_item.op = bcr_pkg::OP_LCALL;
      end
      bcr_pkg::CMD_RST: begin
        push_item.op     = bcr_pkg::OP_CALL;
        push_item.exec   = !(rst_ef_blocked_r && opcode == bcr_pkg::OPC_RST_DEBUG);
        push_item.target = {iir_now, 1'b0, opcode[5:3], 4'b0000};
      end
      bcr_pkg::CMD_SYSCALL: begin
        push_item.op     = bcr_pkg::OP_CALL;
        push_item.target = {iir_now, bcr_pkg::SYSCALL_VEC_LO};
      end
      bcr_pkg::CMD_RET_CC: begin
        push_item.op   = bcr_pkg::OP_RET;
        push_item.exec = cond_in;
      end
      bcr_pkg::CMD_LRET: begin
        push_item.op = bcr_pkg::OP_LRET;
      end
      bcr_pkg::CMD_RETI: begin
        push_item.op = bcr_pkg::OP_RETI;
      end
      bcr_pkg::CMD_DWJNZ: begin
        push_item.op     = bcr_pkg::OP_DWJNZ;
        push_item.target = rel_tgt;
      end
      bcr_pkg::CMD_LLJP_CX: begin
        push_item.op   = bcr_pkg::OP_LLJP;
        push_item.exec = cond_signed;
      end
      bcr_pkg::CMD_LLJP_CC: begin
        push_item.op   = bcr_pkg::OP_LLJP;
        push_item.exec = cond_plain;
      end
      default: begin
        push_item.op   = bcr_pkg::OP_NONE;
        push_item.exec = 1'b0;
      end
    endcase
  end

endmodule

/* design/bcr_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps

module bcr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bcr_pkg::item_t     push_item,
  input  logic               pop,
  output bcr_pkg::item_t     pop_item,
  output bcr_pkg::q_status_t q_status
);

  bcr_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;

  // status and read port
  assign q_status.full  = (fill_r == 2'd2);
  assign q_status.empty = (fill_r == 2'd0);
  assign pop_item       = mem_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/bcr_back.sv */
// back end: carries out the classified command into the output register
`timescale 1ns / 1ps

module bcr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bcr_pkg::q_status_t              q_status,
  input  bcr_pkg::item_t                  pop_item,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bcr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  bcr_pkg::res_t res;
  bcr_pkg::res_t res_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    b_dec;
  logic [15:0]   bc_dec;
  bcr_pkg::item_t it;

  assign it = pop_item;

  // take a new item when the output register is free or being drained
  assign pop = !q_status.empty && (!out_valid_r || out_tready);

  assign b_dec  = it.cnt[7:0] - 8'd1;
  assign bc_dec = it.cnt - 16'd1;

  // resolve the command
  always_comb begin
    res            = '0;
    res.pc_next    = it.pc;
    res.sp_next    = it.sp;
    res.count_next = it.cnt;
    res.xpc_next   = it.xpc;
    case (it.op)
      bcr_pkg::OP_DJNZ: begin
        res.count_next = {it.cnt[15:8], b_dec};
        if (b_dec != 8'd0) begin
          res.pc_next = it.target;
          res.taken   = 1'b1;
        end
      end
      bcr_pkg::OP_DWJNZ: begin
        res.count_next = bc_dec;
        if (bc_dec != 16'd0) begin
          res.pc_next = it.target;
          res.taken   = 1'b1;
        end
      end
      bcr_pkg::OP_JUMP: begin
        if (it.exec) begin
          res.pc_next = it.target;
          res.taken   = 1'b1;
        end
      end
      bcr_pkg::OP_LJP: begin
        res.pc_next   = it.target;
        res.xpc_next  = it.imm_hi[7:0];
        res.xpc_write = 1'b1;
        res.taken     = 1'b1;
      end
      bcr_pkg::OP_CALL: begin
        if (it.exec) begin
          res.push_bytes = {8'h00, it.pc[7:0], it.pc[15:8]};
          res.push_count = 2'd2;
          res.sp_next    = it.sp - 16'd2;
          res.pc_next    = it.target;
          res.taken      = 1'b1;
        end
      end
      bcr_pkg::OP_LCALL: begin
        res.push_bytes = {it.pc[7:0], it.pc[15:8], it.xpc};
        res.push_count = 2'd3;
        res.sp_next    = it.sp - 16'd3;
        res.pc_next    = it.target;
        res.xpc_next   = it.imm_hi[7:0];
        res.xpc_write  = 1'b1;
        res.taken      = 1'b1;
      end
      bcr_pkg::OP_RET: begin
        if (it.exec) begin
          res.pc_next = it.pop[15:0];
          res.sp_next = it.sp + 16'd2;
          res.taken   = 1'b1;
        end
      end
      bcr_pkg::OP_LRET: begin
        res.pc_next   = it.pop[15:0];
        res.xpc_next  = it.pop[23:16];
        res.xpc_write = 1'b1;
        res.sp_next   = it.sp + 16'd3;
        res.taken     = 1'b1;
      end
      bcr_pkg::OP_RETI: begin
        res.ip_next  = it.pop[7:0];
        res.ip_write = 1'b1;
        res.pc_next  = it.pop[23:8];
        res.sp_next  = it.sp + 16'd3;
        res.taken    = 1'b1;
      end
      bcr_pkg::OP_LLJP: begin
        if (it.exec) begin
          res.pc_next    = it.target;
          res.lxpc_next  = it.imm_hi[11:0];
          res.lxpc_write = 1'b1;
          res.taken      = 1'b1;
        end
      end
      default: begin
        res.taken = 1'b0;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res;
    end
  end

  // pack result fields, lowest first
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.taken, res_r.push_bytes, res_r.push_count,
                       res_r.ip_write, res_r.ip_next, res_r.lxpc_write,
                       res_r.lxpc_next, res_r.xpc_write, res_r.xpc_next,
                       res_r.count_next, res_r.sp_next, res_r.pc_next};

endmodule

/* design/branch_call_return_resolver.sv */
// top level: front end, item queue and back end of the resolver
// an input transfer is stored in the queue, then resolved into the output register
// throughput: one item per cycle while out_tready is high, set by the two-entry queue and output register
// a stalled output holds one result; the queue takes two more items, then in_tready drops
// reset (rst_n low, synchronous): config bit cleared, queue emptied, output invalid
`timescale 1ns / 1ps

module branch_call_return_resolver (
  input  logic         clk,
  input  logic         rst_n,
  // config write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data,     // rst_ef_blocked
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, pc_now, sp_now, count_now, flag_byte, cond_in, imm, pop_bytes,
  // xpc_now, iir_now
  input  logic [143:0] in_tdata,
  input  logic [3:0]   in_tuser,     // cmd
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // pc_next, sp_next, count_next, xpc_next, xpc_write, lxpc_next, lxpc_write,
  // ip_next, ip_write, push_count, push_bytes, taken
  output logic [111:0] out_tdata
);

  bcr_pkg::q_status_t q_status;
  bcr_pkg::item_t     push_item;
  bcr_pkg::item_t     pop_item;
  logic               push;
  logic               pop;

  bcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  bcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  bcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/bcr_checker.sv */
// port-level checks for the resolver and their binding
`timescale 1ns / 1ps

module bcr_sva (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // no register write or push without a taken redirect
  a_write_needs_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[105] |->
      !out_tdata[56] && !out_tdata[69] && !out_tdata[78] && out_tdata[80:79] == 2'd0)
    else $error("write enable set on a not-taken result");

  // a two-byte push leaves the third byte clear
  a_two_byte_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[80:79] == 2'd2 |-> out_tdata[104:97] == 8'd0)
    else $error("third push byte set on a two-byte push");

endmodule

bind branch_call_return_resolver bcr_sva u_bcr_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
